@@ rtl/core/rational_sum_reducer_macros.svh @@
// assertion macros shared by the checker
`ifndef RATIONAL_SUM_REDUCER_MACROS_SVH
`define RATIONAL_SUM_REDUCER_MACROS_SVH

// assert that a consequent follows an antecedent in the same cycle
`define RSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// assert that a consequent follows an antecedent in the next cycle
`define RSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rsr_pkg.sv @@
// shared types and constants for the rational sum reducer
package rsr_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_ZERO_DEN = 2'd2
  } status_e;

  // back end sequencer states
  typedef enum logic [3:0] {
    BE_IDLE,
    BE_MUL1,
    BE_MUL2,
    BE_MUL3,
    BE_ADD,
    BE_FINAL,
    BE_GCD,
    BE_DIV,
    BE_OUT
  } be_state_e;

endpackage

@@ rtl/core/rsr_front.sv @@
// front end: input register and classification into a small queue
module rsr_front #(
  parameter int TERM_WIDTH = 16,
  parameter int QDEPTH     = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [TERM_WIDTH-1:0] term_numerator_i,
  input  logic        [TERM_WIDTH-1:0] term_denominator_i,
  input  logic                         last_term_i,
  output logic                         q_valid_o,
  input  logic                         q_pop_i,
  output logic signed [TERM_WIDTH-1:0] q_num_o,
  output logic        [TERM_WIDTH-1:0] q_den_o,
  output logic                         q_last_o,
  output logic                         q_zero_den_o
);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int EW = 2 * TERM_WIDTH + 2;

  logic [EW-1:0] mem_q [QDEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          push, pop;
  logic [EW-1:0] head;

  assign in_stall_o = (cnt_q == PW'(0) + (PW+1)'(QDEPTH));
  assign push = in_valid_i && !in_stall_o;
  assign pop  = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != '0);
  assign head = mem_q[rd_q];
  assign q_num_o = head[EW-1 -: TERM_WIDTH];
  assign q_den_o = head[TERM_WIDTH+1 -: TERM_WIDTH];
  assign q_last_o = head[1];
  assign q_zero_den_o = head[0];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= {term_numerator_i, term_denominator_i, last_term_i,
                      (term_denominator_i == '0)};
    end
  end
endmodule

@@ rtl/core/rsr_back.sv @@
// back end: multiply-accumulate, gcd reduction and result register
module rsr_back #(
  parameter int ACC_WIDTH  = 64,
  parameter int TERM_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  logic signed [TERM_WIDTH-1:0] q_num_i,
  input  logic        [TERM_WIDTH-1:0] q_den_i,
  input  logic                         q_last_i,
  input  logic                         q_zero_den_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [63:0]           sum_numerator_o,
  output logic        [62:0]           sum_denominator_o,
  output logic        [1:0]            status_o
);
  import rsr_pkg::*;
  localparam int AW = ACC_WIDTH;
  localparam int PW = AW + TERM_WIDTH + 1;
  localparam int CW = $clog2(AW + 1);

  be_state_e state_q, state_d;
  logic signed [AW-1:0] num_q;
  logic [AW-1:0] den_q;
  logic [1:0] err_q;
  logic signed [TERM_WIDTH-1:0] tn_q;
  logic [TERM_WIDTH-1:0] td_q;
  logic tl_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic [PW-1:0] pd_q;
  // gcd and division registers
  logic [AW-1:0] ga_q, gb_q, rem_q, quo_q, dvd_q, dvs_q;
  logic [CW-1:0] bit_q;
  logic div_for_gcd_q, div_num_q;
  logic [AW-1:0] g_q;
  logic neg_q;
  logic out_v_q;
  logic signed [63:0] on_q;
  logic [62:0] od_q;
  logic [1:0] os_q;
  logic ovf;
  logic signed [PW:0] sum_w;
  logic signed [PW-1:0] hi_lim, lo_lim;
  logic [AW:0] rem_sh;

  assign hi_lim = PW'((64'(1) << (AW - 1)) - 64'(1));
  assign lo_lim = -hi_lim - PW'(1);
  assign sum_w = {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};
  assign ovf = (p1_q > hi_lim) || (p1_q < lo_lim) || (p2_q > hi_lim) || (p2_q < lo_lim) ||
               (sum_w > (PW+1)'(hi_lim)) || (sum_w < (PW+1)'(lo_lim)) ||
               (pd_q > PW'(hi_lim));
  assign rem_sh = {rem_q, dvd_q[AW-1]};

  assign q_pop_o = (state_q == BE_IDLE) && q_valid_i && !out_v_q;
  assign out_valid_o = out_v_q;
  assign sum_numerator_o = on_q;
  assign sum_denominator_o = od_q;
  assign status_o = os_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE: begin
        if (q_pop_o) begin
          state_d = (q_zero_den_i || err_q != STATUS_OK) ? BE_FINAL : BE_MUL1;
        end
      end
      BE_MUL1: state_d = BE_MUL2;
      BE_MUL2: state_d = BE_MUL3;
      BE_MUL3: state_d = BE_ADD;
      BE_ADD:  state_d = BE_FINAL;
      BE_FINAL: begin
        if (!tl_q) begin
          state_d = BE_IDLE;
        end else if (err_q != STATUS_OK || num_q == '0) begin
          state_d = BE_OUT;
        end else begin
          state_d = BE_GCD;
        end
      end
      BE_GCD: state_d = (gb_q == '0) ? BE_DIV : BE_GCD;
      BE_DIV: begin
        if (bit_q == '0 && !div_for_gcd_q && div_num_q) state_d = BE_OUT;
      end
      BE_OUT: state_d = BE_IDLE;
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      num_q <= '0;
      den_q <= AW'(1);
      err_q <= STATUS_OK;
      out_v_q <= 1'b0;
      tl_q <= 1'b0;
      bit_q <= '0;
      div_for_gcd_q <= 1'b0;
      div_num_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      case (state_q)
        BE_IDLE: begin
          if (q_pop_o) begin
            tl_q <= q_last_i;
            if (q_zero_den_i) err_q <= STATUS_ZERO_DEN;
          end
        end
        BE_ADD: begin
          if (ovf) begin
            err_q <= STATUS_OVERFLOW;
          end else begin
            num_q <= AW'(sum_w);
            den_q <= AW'(pd_q);
          end
        end
        BE_FINAL: begin
          if (tl_q && !(err_q != STATUS_OK || num_q == '0)) begin
            div_for_gcd_q <= 1'b1;
            bit_q <= CW'(AW);
          end
        end
        BE_GCD: begin
          // one remainder a pass: shift-subtract down the bits, then swap
          if (gb_q != '0) begin
            if (bit_q != '0) begin
              bit_q <= bit_q - CW'(1);
            end else begin
              bit_q <= CW'(AW);
            end
          end else begin
            div_for_gcd_q <= 1'b0;
            div_num_q <= 1'b0;
            bit_q <= CW'(AW);
          end
        end
        BE_DIV: begin
          if (bit_q != '0) begin
            bit_q <= bit_q - CW'(1);
          end else if (!div_num_q) begin
            div_num_q <= 1'b1;
            bit_q <= CW'(AW);
          end
        end
        BE_OUT: begin
          out_v_q <= 1'b1;
          num_q <= '0;
          den_q <= AW'(1);
          err_q <= STATUS_OK;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BE_IDLE: begin
        tn_q <= q_num_i;
        td_q <= q_den_i;
      end
      BE_MUL1: p1_q <= PW'(num_q) * $signed({1'b0, td_q});
      BE_MUL2: p2_q <= PW'(tn_q) * $signed({1'b0, den_q});
      BE_MUL3: pd_q <= PW'(den_q) * PW'(td_q);
      BE_FINAL: begin
        neg_q <= num_q[AW-1];
        ga_q <= num_q[AW-1] ? AW'(-num_q) : AW'(num_q);
        gb_q <= den_q;
        rem_q <= '0;
        dvd_q <= num_q[AW-1] ? AW'(-num_q) : AW'(num_q);
        on_q <= '0;
        od_q <= 63'd1;
      end
      BE_GCD: begin
        if (gb_q != '0) begin
          if (bit_q != '0) begin
            // restoring division step of ga mod gb
            if (rem_sh >= {1'b0, gb_q}) rem_q <= AW'(rem_sh - {1'b0, gb_q});
            else rem_q <= rem_sh[AW-1:0];
            dvd_q <= dvd_q << 1;
          end else begin
            ga_q <= gb_q;
            gb_q <= rem_q;
            dvd_q <= gb_q;
            rem_q <= '0;
          end
        end else begin
          g_q <= ga_q;
          dvd_q <= den_q;
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      BE_DIV: begin
        if (bit_q != '0) begin
          if (rem_sh >= {1'b0, g_q}) begin
            rem_q <= AW'(rem_sh - {1'b0, g_q});
            quo_q <= {quo_q[AW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[AW-1:0];
            quo_q <= {quo_q[AW-2:0], 1'b0};
          end
          dvd_q <= dvd_q << 1;
        end else if (!div_num_q) begin
          od_q <= 63'(quo_q);
          dvd_q <= neg_q ? AW'(-num_q) : AW'(num_q);
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          on_q <= 64'(neg_q ? $signed(-quo_q) : $signed(quo_q));
        end
      end
      BE_OUT: os_q <= err_q;
      default: ;
    endcase
  end
endmodule

@@ rtl/core/rational_sum_reducer.sv @@
// top level of the rational sum reducer
// Adds signed fractions n/d, one per input word, into a running numerator and
// positive denominator by cross-multiplication; on the word marked last the
// sum is reduced by gcd(|num|, den) and one result word leaves, after which the
// accumulator clears. A front queue takes words while the back end works.
// A term passes pop, three registered multiplies, the add with its overflow
// check and wrap-up; a term skipped after an error or with a zero denominator
// goes from pop straight to wrap-up; a last term adds a shift-subtract Euclid
// run, one pass per remainder, plus two shift-subtract divisions.
// status: 0 ok, 1 overflow, 2 zero denominator (fields then read 0/1).
module rational_sum_reducer #(
  parameter int ACC_WIDTH  = 64,
  parameter int TERM_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [TERM_WIDTH-1:0] term_numerator_i,
  input  logic        [TERM_WIDTH-1:0] term_denominator_i,
  input  logic                         last_term_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [63:0]           sum_numerator_o,
  output logic        [62:0]           sum_denominator_o,
  output logic        [1:0]            status_o
);
  logic q_valid, q_pop, q_last, q_zero;
  logic signed [TERM_WIDTH-1:0] q_num;
  logic [TERM_WIDTH-1:0] q_den;

  // front: queue of classified words
  rsr_front #(.TERM_WIDTH(TERM_WIDTH), .QDEPTH(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .term_numerator_i,
    .term_denominator_i, .last_term_i, .q_valid_o(q_valid), .q_pop_i(q_pop),
    .q_num_o(q_num), .q_den_o(q_den), .q_last_o(q_last), .q_zero_den_o(q_zero)
  );

  // back: arithmetic and reduction
  rsr_back #(.ACC_WIDTH(ACC_WIDTH), .TERM_WIDTH(TERM_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_num_i(q_num),
    .q_den_i(q_den), .q_last_i(q_last), .q_zero_den_i(q_zero), .out_valid_o,
    .out_stall_i, .sum_numerator_o, .sum_denominator_o, .status_o
  );
endmodule

@@ rtl/core/rsr_checker.sv @@
// port-level assertions for the rational sum reducer
`include "rational_sum_reducer_macros.svh"
module rsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [62:0] sum_denominator_o,
  input logic [63:0] sum_numerator_o,
  input logic [1:0]  status_o
);
  import rsr_pkg::*;

  logic err_word;
  logic err_fields;
  logic out_held;

  assign err_word   = out_valid_o && (status_o != STATUS_OK);
  assign err_fields = (sum_numerator_o == '0) && (sum_denominator_o == 63'd1);
  assign out_held   = out_valid_o && out_stall_i;

  `RSR_ASSERT_IMP(a_den_pos, clk_i, rst_ni, out_valid_o, sum_denominator_o != '0, "zero den")
  `RSR_ASSERT_IMP(a_status, clk_i, rst_ni, out_valid_o, status_o != 2'd3, "bad status")
  `RSR_ASSERT_IMP(a_err_zero, clk_i, rst_ni, err_word, err_fields, "error fields")
  `RSR_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_held,
                   out_valid_o && $stable(sum_numerator_o), "stall hold")
endmodule

bind rational_sum_reducer rsr_checker u_rsr_checker (.*);

@@ test/rational_sum_reducer_tb.sv @@
// testbench for the rational sum reducer: directed and random fraction runs
`timescale 1ns / 1ps

module rational_sum_reducer_tb;
  import rsr_pkg::*;

  localparam logic [63:0] ACC_LIMIT = 64'h8000_0000_0000_0000;

  // one reduced sum as it leaves the block
  typedef struct {
    logic signed [63:0] num;
    logic        [62:0] den;
    status_e            st;
  } frac_t;

  // one row of the directed table; typed rows carry their own expected sum
  typedef struct {
    logic signed [15:0] num;
    logic        [15:0] den;
    bit                 last;
    bit                 typed;
    logic signed [63:0] exp_num;
    logic        [62:0] exp_den;
    status_e            exp_st;
  } term_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] term_numerator_i = '0;
  logic        [15:0] term_denominator_i = '0;
  logic               last_term_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [63:0] sum_numerator_o;
  logic        [62:0] sum_denominator_o;
  logic        [1:0]  status_o;

  // running sum kept by the predictor
  longint             run_num = 0;
  logic        [63:0] run_den = 64'd1;
  status_e            run_st = STATUS_OK;

  frac_t sums_q[$];
  int    errors = 0;
  int    sent = 0;
  bit    quiet = 1'b0;   // no idling on either side while set

  always #10 clk_i = ~clk_i;

  rational_sum_reducer u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .term_numerator_i   (term_numerator_i),
    .term_denominator_i (term_denominator_i),
    .last_term_i        (last_term_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sum_numerator_o    (sum_numerator_o),
    .sum_denominator_o  (sum_denominator_o),
    .status_o           (status_o)
  );

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // x * y inside the signed 64-bit range, y nonzero
  function automatic bit scale_fits(input longint x, input logic [63:0] y,
                                    output longint r);
    logic [63:0] mag;
    logic [63:0] prod;
    mag = (x < 0) ? 64'd0 - x : x;
    if (mag > ACC_LIMIT / y) return 1'b0;
    prod = mag * y;
    if (x < 0) begin
      r = longint'(64'd0 - prod);
      return 1'b1;
    end
    if (prod >= ACC_LIMIT) return 1'b0;
    r = longint'(prod);
    return 1'b1;
  endfunction

  function automatic bit sum_fits(input longint a, input longint b, output longint r);
    longint hi;
    longint lo;
    hi = 64'sh7fff_ffff_ffff_ffff;
    lo = -hi - 1;
    if (b > 0 && a > hi - b) return 1'b0;
    if (b < 0 && a < lo - b) return 1'b0;
    r = a + b;
    return 1'b1;
  endfunction

  function automatic logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // fold one term into the running sum; returns 1 with the reduced sum on a last term
  function automatic bit fold_term(input logic signed [15:0] n, input logic [15:0] d,
                                   input bit last, output frac_t res);
    longint      p1, p2, s, dd;
    logic [63:0] mag, g, rd;
    longint      n64;
    n64 = n;
    if (d == 0) begin
      run_st = STATUS_ZERO_DEN;
    end else if (run_st == STATUS_OK) begin
      // overflow anywhere leaves the sum untouched
      if (scale_fits(run_num, {48'd0, d}, p1) && scale_fits(n64, run_den, p2) &&
          sum_fits(p1, p2, s) && scale_fits(longint'(run_den), {48'd0, d}, dd)) begin
        run_num = s;
        run_den = dd;
      end else begin
        run_st = STATUS_OVERFLOW;
      end
    end
    if (!last) return 1'b0;
    res.num = 0;
    rd      = 64'd1;
    res.st  = run_st;
    if (run_st == STATUS_OK && run_num != 0) begin
      mag     = (run_num < 0) ? 64'd0 - run_num : run_num;
      g       = euclid(mag, run_den);
      mag     = mag / g;
      rd      = run_den / g;
      res.num = (run_num < 0) ? 64'd0 - mag : mag;
    end
    res.den = rd[62:0];
    run_num = 0;
    run_den = 64'd1;
    run_st  = STATUS_OK;
    return 1'b1;
  endfunction

  // present one word and hold it until taken; the caller may supply a typed expectation
  task automatic send_term(input logic signed [15:0] n, input logic [15:0] d,
                           input bit last, input bit typed, input frac_t typed_sum);
    frac_t res;
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    term_numerator_i   <= n;
    term_denominator_i <= d;
    last_term_i        <= last;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (fold_term(n, d, last, res)) sums_q.push_back(typed ? typed_sum : res);
  endtask

  // sender backs off until every pending sum has come out
  task automatic drain_sums();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (sums_q.size() == 0);
    @(posedge clk_i);
  endtask

  // result side: random stall and the check of each accepted word
  always @(posedge clk_i) begin
    frac_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sums_q.size() == 0) begin
          report("result word with no sum pending");
        end else begin
          want = sums_q.pop_front();
          if (sum_numerator_o !== want.num)
            report($sformatf("numerator %0d, want %0d", sum_numerator_o, want.num));
          if (sum_denominator_o !== want.den)
            report($sformatf("denominator %0d, want %0d", sum_denominator_o, want.den));
          if (status_o !== want.st)
            report($sformatf("status %0d, want %0d", status_o, want.st));
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 27);
    end
  end

  // directed table: extremes, reduction, cancellation to zero, both error codes
  term_row_t term_rows[] = '{
    '{16'sd32767,  16'd1,     1, 1, 64'sd32767,  63'd1,     STATUS_OK},
    '{-16'sd32768, 16'd1,     1, 1, -64'sd32768, 63'd1,     STATUS_OK},
    '{16'sd0,      16'd5,     1, 1, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd1,      16'd65535, 1, 1, 64'sd1,      63'd65535, STATUS_OK},
    '{16'sd6,      16'd4,     1, 1, 64'sd3,      63'd2,     STATUS_OK},
    '{-16'sd6,     16'd4,     1, 1, -64'sd3,     63'd2,     STATUS_OK},
    '{16'sd5,      16'd0,     1, 1, 64'sd0,      63'd1,     STATUS_ZERO_DEN},
    // 1/2 + 1/3 - 5/6 cancels to zero
    '{16'sd1,      16'd2,     0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd1,      16'd3,     0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{-16'sd5,     16'd6,     1, 1, 64'sd0,      63'd1,     STATUS_OK},
    // zero denominator in mid run poisons the run
    '{16'sd1,      16'd2,     0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd1,      16'd0,     0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd1,      16'd3,     1, 1, 64'sd0,      63'd1,     STATUS_ZERO_DEN},
    // denominator 65535^4 passes 2^63
    '{16'sd1,      16'd65535, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd1,      16'd65535, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd1,      16'd65535, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd1,      16'd65535, 1, 1, 64'sd0,      63'd1,     STATUS_OVERFLOW},
    // overflow then zero denominator raises the code
    '{-16'sd32768, 16'd65535, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd32767,  16'd65534, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{-16'sd32768, 16'd65533, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd32767,  16'd65532, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd7,      16'd0,     1, 1, 64'sd0,      63'd1,     STATUS_ZERO_DEN},
    // extremes mixed, checked by the predictor
    '{-16'sd32768, 16'd65535, 0, 0, 64'sd0,      63'd1,     STATUS_OK},
    '{16'sd32767,  16'd65535, 1, 0, 64'sd0,      63'd1,     STATUS_OK}
  };

  initial begin
    frac_t typed_sum;
    frac_t none;
    int    run_len;
    int    kind;
    logic signed [15:0] n;
    logic        [15:0] d;
    none = '{0, 1, STATUS_OK};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (term_rows[i]) begin
      typed_sum = '{term_rows[i].exp_num, term_rows[i].exp_den, term_rows[i].exp_st};
      send_term(term_rows[i].num, term_rows[i].den, term_rows[i].last,
                term_rows[i].typed, typed_sum);
    end
    drain_sums();

    // random runs: mostly short well-formed sums, some long or broken ones
    while (sent < 1575) begin
      if (sent > 700 && sent < 950) quiet = 1'b1;
      else quiet = 1'b0;
      if (sent > 1100 && sent < 1110) drain_sums();
      kind    = $urandom_range(99);
      run_len = (kind < 80) ? $urandom_range(1, 5) : $urandom_range(4, 12);
      for (int k = 0; k < run_len; k++) begin
        n = 16'($urandom());
        if ($urandom_range(3) == 0) n = $signed(16'($urandom_range(0, 40))) - 16'sd20;
        case ($urandom_range(19))
          0:       d = 16'd0;
          1, 2, 3: d = 16'($urandom());
          default: d = 16'($urandom_range(1, 64));
        endcase
        send_term(n, d, k == run_len - 1, 1'b0, none);
      end
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;
    wait (sums_q.size() == 0);
    repeat (500) @(posedge clk_i);
    if (errors == 0) begin
      $display("** rational_sum_reducer: PASSED **");
    end else begin
      $display("** rational_sum_reducer: FAILED **");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(1_000_000_000);
    $display("** rational_sum_reducer: FAILED **");
    $finish;
  end

endmodule
